[src/grf_pkg.sv]
// Package for the Givens rotation generator.
// Holds fixed field widths and the code fraction width; no dependencies.
package grf_pkg;
  localparam int unsigned CsWidth = 16;
  localparam int unsigned XiWidth = 32;
  localparam int unsigned XiFrac  = 15;
endpackage

[src/grf_if.sv]
// Valid/ready channel interfaces for the Givens rotation generator.
// Result field widths are written out in the interfaces; no dependency on grf_pkg.
interface grf_in_if #(parameter int unsigned W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] operand_a;
  logic [W-1:0] operand_b;
  modport source (output valid, operand_a, operand_b, input ready);
  modport sink   (input valid, operand_a, operand_b, output ready);
endinterface

interface grf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cosine;
  logic [15:0] sine;
  logic [31:0] rotation_code;
  logic        code_saturated;
  modport source (output valid, cosine, sine, rotation_code, code_saturated, input ready);
  modport sink   (input valid, cosine, sine, rotation_code, code_saturated, output ready);
endinterface

[src/grf_cell.sv]
// One root-bit cell of the rotation pipeline.
// Decides one bit of the largest k with k*k*w <= target, using shifts and adds only.
module grf_cell #(
  parameter int unsigned KW   = 33,
  parameter int unsigned WW   = 32,
  parameter int unsigned TW   = 64,
  parameter int unsigned BIT  = 0,
  parameter bit          LIVE = 1'b1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [WW-1:0] w_i,
  input  logic [KW-1:0] k_i,
  input  logic [TW-1:0] e_i,
  input  logic [TW-1:0] p_i,
  output logic [WW-1:0] w_o,
  output logic [KW-1:0] k_o,
  output logic [TW-1:0] e_o,
  output logic [TW-1:0] p_o
);
  // e_i holds target - k*k*w, p_i holds k*w; k has bits above BIT only
  logic [TW-1:0] wsq;
  logic [TW:0]   d;
  logic [TW+1:0] diff;
  logic          ov;
  logic          take;

  // Weight shifted by twice the bit; drop the bit when it cannot fit
  if (!LIVE || 2 * BIT >= TW) begin : g_off
    assign ov  = 1'b1;
    assign wsq = '0;
  end else begin : g_on
    assign ov  = |(TW'(w_i) >> (TW - 2 * BIT));
    assign wsq = TW'(w_i) << (2 * BIT);
  end

  // Growth of k*k*w when this bit is set, compared against the remainder
  always_comb begin
    d    = (TW+1)'(p_i << (BIT + 1)) + (TW+1)'(wsq);
    diff = (TW+2)'(e_i) - (TW+2)'(d);
    take = !ov && !diff[TW+1];
  end

  // Advance the partial root and its running terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_o <= w_i;
      k_o <= take ? (k_i | (KW'(1) << BIT)) : k_i;
      e_o <= take ? diff[TW-1:0] : e_i;
      p_o <= take ? (p_i + (TW'(w_i) << BIT)) : p_i;
    end
  end
endmodule

[src/givens_rotation_find_with_code_unit.sv]
// Top level of the Givens rotation generator: a chain of root-bit cells per quantity.
// Depends on grf_pkg, grf_if and grf_cell.
//
//  channel | dir | beat contents
//  in      | in  | operand_a, operand_b
//  out     | out | cosine, sine, rotation_code, code_saturated
//
// One beat per cycle sustained while the output is taken. The setup stage loads on the
// accepting edge, then 33 root-bit cells and the output register follow (33 bits
// are enough for the widest root, the code).
// The whole pipeline advances when the output register is empty or taken;
// a stall on the output freezes every stage. Reset clears valid bits only.
module givens_rotation_find_with_code_unit #(
  parameter int unsigned IN_WIDTH = 16,
  parameter int unsigned CS_FRAC_BITS = 14
) (
  input logic clk_i,
  input logic rst_ni,
  grf_in_if.sink    in_i,
  grf_out_if.source out_o
);
  import grf_pkg::*;
  localparam int unsigned MW      = 2 * IN_WIDTH;
  localparam int unsigned KW      = 33;
  localparam int unsigned NS      = KW;
  localparam int unsigned CsShift = 2 * CS_FRAC_BITS + 2;
  localparam int unsigned XiShift = 2 * XiFrac + 2;
  localparam int unsigned TW      = MW + ((CsShift > XiShift) ? CsShift : XiShift);

  logic [NS+1:0] vld_q;
  logic          adv;
  assign adv = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // Magnitudes, squares and case flags of the incoming beat
  logic [IN_WIDTH-1:0] mag_a, mag_b;
  logic [MW-1:0]       sq_a, sq_b, sum_sq;
  logic                big_d;
  always_comb begin
    mag_a  = in_i.operand_a[IN_WIDTH-1] ? -in_i.operand_a : in_i.operand_a;
    mag_b  = in_i.operand_b[IN_WIDTH-1] ? -in_i.operand_b : in_i.operand_b;
    sq_a   = MW'(mag_a) * MW'(mag_a);
    sq_b   = MW'(mag_b) * MW'(mag_b);
    sum_sq = sq_a + sq_b;
    big_d  = mag_a >= mag_b;
  end

  // Setup stage: weights and targets of the three root chains, flags per stage
  logic [MW-1:0] m_q, xi_w_q;
  logic [TW-1:0] cos_t_q, sin_t_q, xi_t_q;
  logic [NS:0]   az_q, bz_q, big_q, same_q, bpos_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q     <= sum_sq;
      cos_t_q <= TW'(sq_a) << CsShift;
      sin_t_q <= TW'(sq_b) << CsShift;
      xi_w_q  <= big_d ? sum_sq : sq_a;
      xi_t_q  <= big_d ? (TW'(sq_b) << XiShift) : (TW'(sum_sq) << XiShift);
      az_q    <= {az_q[NS-1:0], mag_a == '0};
      bz_q    <= {bz_q[NS-1:0], mag_b == '0};
      big_q   <= {big_q[NS-1:0], big_d};
      same_q  <= {same_q[NS-1:0],
                  in_i.operand_a[IN_WIDTH-1] == in_i.operand_b[IN_WIDTH-1]};
      bpos_q  <= {bpos_q[NS-1:0], !in_i.operand_b[IN_WIDTH-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NS:0], in_i.valid};
  end

  // Cell chains: cosine and sine need the low frac+2 bits, the code all 33
  logic [KW-1:0] cos_k [NS+1], sin_k [NS+1], xi_k [NS+1];
  logic [TW-1:0] cos_e [NS+1], sin_e [NS+1], xi_e [NS+1];
  logic [TW-1:0] cos_p [NS+1], sin_p [NS+1], xi_p [NS+1];
  logic [MW-1:0] cos_w [NS+1], sin_w [NS+1], xi_w [NS+1];

  assign cos_k[0] = '0;
  assign cos_e[0] = cos_t_q;
  assign cos_p[0] = '0;
  assign cos_w[0] = m_q;
  assign sin_k[0] = '0;
  assign sin_e[0] = sin_t_q;
  assign sin_p[0] = '0;
  assign sin_w[0] = m_q;
  assign xi_k[0]  = '0;
  assign xi_e[0]  = xi_t_q;
  assign xi_p[0]  = '0;
  assign xi_w[0]  = xi_w_q;

  for (genvar k = 0; k < NS; k++) begin : g_chain
    localparam int unsigned BX = NS - 1 - k;
    grf_cell #(.KW(KW), .WW(MW), .TW(TW), .BIT(BX), .LIVE(BX <= CS_FRAC_BITS + 1)) u_c (
      .clk_i, .en_i(adv), .w_i(cos_w[k]), .k_i(cos_k[k]), .e_i(cos_e[k]),
      .p_i(cos_p[k]), .w_o(cos_w[k+1]), .k_o(cos_k[k+1]), .e_o(cos_e[k+1]),
      .p_o(cos_p[k+1]));
    grf_cell #(.KW(KW), .WW(MW), .TW(TW), .BIT(BX), .LIVE(BX <= CS_FRAC_BITS + 1)) u_s (
      .clk_i, .en_i(adv), .w_i(sin_w[k]), .k_i(sin_k[k]), .e_i(sin_e[k]),
      .p_i(sin_p[k]), .w_o(sin_w[k+1]), .k_o(sin_k[k+1]), .e_o(sin_e[k+1]),
      .p_o(sin_p[k+1]));
    grf_cell #(.KW(KW), .WW(MW), .TW(TW), .BIT(BX), .LIVE(1'b1)) u_x (
      .clk_i, .en_i(adv), .w_i(xi_w[k]), .k_i(xi_k[k]), .e_i(xi_e[k]),
      .p_i(xi_p[k]), .w_o(xi_w[k+1]), .k_o(xi_k[k+1]), .e_o(xi_e[k+1]),
      .p_o(xi_p[k+1]));
  end

  // Round each root to nearest: half of k+1; cap the code at 2^31
  logic [KW:0]   cos_sum, sin_sum, xi_sum;
  logic [KW-1:0] qc, qs, qx;
  always_comb begin
    cos_sum = (KW+1)'(cos_k[NS]) + (KW+1)'(1);
    sin_sum = (KW+1)'(sin_k[NS]) + (KW+1)'(1);
    xi_sum  = (KW+1)'(xi_k[NS]) + (KW+1)'(1);
    qc = cos_sum[KW:1];
    qs = sin_sum[KW:1];
    qx = (xi_sum[KW:1] > (KW'(1) << (XiWidth - 1))) ? (KW'(1) << (XiWidth - 1))
                                                     : xi_sum[KW:1];
  end

  // Sign, special cases and output register
  logic [CsWidth-1:0] c_v, s_v;
  logic [XiWidth-1:0] x_v;
  logic               f_v;
  logic               az, bz;
  always_comb begin
    az = az_q[NS];
    bz = bz_q[NS];
    f_v = 1'b0;
    if (big_q[NS]) begin
      if (az) begin
        c_v = CsWidth'(KW'(1) << CS_FRAC_BITS); s_v = '0; x_v = '0;
      end else begin
        c_v = CsWidth'(qc);
        s_v = bz ? '0 : (same_q[NS] ? CsWidth'(-qs) : CsWidth'(qs));
        x_v = bz ? '0 : (same_q[NS] ? XiWidth'(-qx) : XiWidth'(qx));
      end
    end else begin
      c_v = az ? '0 : (same_q[NS] ? CsWidth'(qc) : CsWidth'(-qc));
      s_v = CsWidth'(-qs);
      if (az) begin
        f_v = 1'b1;
        x_v = bpos_q[NS] ? 32'h7fff_ffff : 32'h8000_0000;
      end else if (same_q[NS]) begin
        x_v = qx > KW'(32'h7fff_ffff) ? 32'h7fff_ffff : XiWidth'(qx);
      end else begin
        x_v = XiWidth'(-qx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.cosine <= c_v; out_o.sine <= s_v;
      out_o.rotation_code <= x_v; out_o.code_saturated <= f_v;
    end
  end
  assign out_o.valid = vld_q[NS+1];

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q)) else $error("pipeline moved during stall");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.code_saturated |-> out_o.cosine == '0)
    else $error("saturated code with nonzero cosine");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready) else $error("ready low with empty output");
`endif
endmodule

[tb/grf_rotation_checker.sv]
// Checker for the Givens rotation generator: watches both channels, predicts each result.
// Depends on grf_pkg and the grf_in_if / grf_out_if interfaces.
module grf_rotation_checker (
  input  logic clk_i,
  input  logic rst_ni,
  grf_in_if    in_mon,
  grf_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   saturated_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import grf_pkg::*;

  localparam int unsigned CsFrac = 14;

  typedef struct packed {
    logic [CsWidth-1:0] cosine;
    logic [CsWidth-1:0] sine;
    logic [XiWidth-1:0] rotation_code;
    logic               code_saturated;
  } rotation_t;

  rotation_t rotations_due[$];

  // round(n * 2^f / sqrt(m)), for 0 < n*n <= m
  function automatic longint unsigned scaled_ratio(longint unsigned n, longint unsigned m,
                                                   int f);
    longint unsigned q, cand, t, qmax;
    logic [127:0] lhs, rhs;
    q = 0;
    qmax = 64'd1 << f;
    rhs = (128'(n) * 128'(n)) << (2 * f + 2);
    for (int bit_i = f; bit_i >= 0; bit_i--) begin
      cand = q | (64'd1 << bit_i);
      if (cand <= qmax) begin
        t = 2 * cand - 1;
        lhs = 128'(t) * 128'(t) * 128'(m);
        if (lhs <= rhs) q = cand;
      end
    end
    return q;
  endfunction

  // round(sqrt(m) * 2^15 / n), capped at 2^31, for n > 0
  function automatic longint unsigned scaled_inverse(longint unsigned n, longint unsigned m);
    longint unsigned q, cand, qmax;
    logic [127:0] u, rhs;
    q = 0;
    qmax = 64'd1 << 31;
    rhs = 128'(m) << (2 * XiFrac + 2);
    for (int bit_i = 31; bit_i >= 0; bit_i--) begin
      cand = q | (64'd1 << bit_i);
      if (cand <= qmax) begin
        u = 128'(2 * cand - 1) * 128'(n);
        if (u * u <= rhs) q = cand;
      end
    end
    return q;
  endfunction

  function automatic rotation_t predict_rotation(logic signed [15:0] a, logic signed [15:0] b);
    longint unsigned mag_a, mag_b, sum_sq, mag;
    longint c, s, xi;
    logic same;
    rotation_t r;
    mag_a = (a < 0) ? -longint'(a) : longint'(a);
    mag_b = (b < 0) ? -longint'(b) : longint'(b);
    sum_sq = mag_a * mag_a + mag_b * mag_b;
    same = (a < 0) == (b < 0);
    r.code_saturated = 1'b0;
    if (mag_a >= mag_b) begin
      if (mag_a == 0) begin
        c = longint'(64'd1 << CsFrac);
        s = 0;
        xi = 0;
      end else begin
        c = longint'(scaled_ratio(mag_a, sum_sq, CsFrac));
        s = 0;
        xi = 0;
        if (mag_b != 0) begin
          s = longint'(scaled_ratio(mag_b, sum_sq, CsFrac));
          xi = longint'(scaled_ratio(mag_b, sum_sq, XiFrac));
          if (same) begin
            s = -s;
            xi = -xi;
          end
        end
      end
    end else begin
      c = 0;
      if (mag_a != 0) begin
        c = longint'(scaled_ratio(mag_a, sum_sq, CsFrac));
        if (!same) c = -c;
      end
      s = -longint'(scaled_ratio(mag_b, sum_sq, CsFrac));
      if (mag_a == 0) begin
        // infinite code: saturate toward the sign of b
        xi = (b > 0) ? 64'sd2147483647 : -64'sd2147483648;
        r.code_saturated = 1'b1;
      end else begin
        mag = scaled_inverse(mag_a, sum_sq);
        if (same) begin
          if (mag > 64'd2147483647) mag = 64'd2147483647;
          xi = longint'(mag);
        end else begin
          xi = -longint'(mag);
        end
      end
    end
    r.cosine = c[CsWidth-1:0];
    r.sine = s[CsWidth-1:0];
    r.rotation_code = xi[XiWidth-1:0];
    return r;
  endfunction

  rotation_t seen, due;

  assign pending_o = rotations_due.size();

  // Queue a prediction per input beat, compare each output beat with the oldest one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
      checked_o <= 0;
      saturated_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        rotations_due.push_back(predict_rotation(in_mon.operand_a, in_mon.operand_b));
      if (out_mon.valid && out_mon.ready) begin
        seen = '{out_mon.cosine, out_mon.sine, out_mon.rotation_code, out_mon.code_saturated};
        if (rotations_due.size() == 0) begin
          $display("%0t: output beat with nothing expected: %h", $time, seen);
          fail_count_o <= fail_count_o + 1;
        end else begin
          due = rotations_due.pop_front();
          checked_o <= checked_o + 1;
          if (due.code_saturated) saturated_o <= saturated_o + 1;
          if (seen.cosine !== due.cosine)
            $display("%0t: cosine expected %h actual %h", $time, due.cosine, seen.cosine);
          if (seen.sine !== due.sine)
            $display("%0t: sine expected %h actual %h", $time, due.sine, seen.sine);
          if (seen.rotation_code !== due.rotation_code)
            $display("%0t: rotation_code expected %h actual %h", $time,
                     due.rotation_code, seen.rotation_code);
          if (seen.code_saturated !== due.code_saturated)
            $display("%0t: code_saturated expected %b actual %b", $time,
                     due.code_saturated, seen.code_saturated);
          if (seen !== due) fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end
endmodule

[tb/tb_givens_rotation_find_with_code_unit.sv]
// Testbench top for the Givens rotation generator: clock, reset, stimulus and verdict.
// Depends on grf_pkg, the grf interfaces, the block and grf_rotation_checker.
module tb_givens_rotation_find_with_code_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBeats = 1830;
  localparam int IdleLimit   = 4000;
  localparam int Latency     = 34;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending, checked, saturated;
  int   idle_cycles = 0;
  bit   stimulus_done;

  grf_in_if #(.W(16)) in_ch ();
  grf_out_if          out_ch ();

  givens_rotation_find_with_code_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  grf_rotation_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .saturated_o (saturated)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, sometimes short, rarely long
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(4, 1);
    return $urandom_range(40, 5);
  endfunction

  // Present one beat and hold it until accepted
  task automatic send_beat(logic [15:0] a, logic [15:0] b);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.operand_a = a;
    in_ch.operand_b = b;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] random_operand();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(16) - 8);
      2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                  : 16'h8000 + 16'($urandom_range(3));
      default: return 16'($signed(16'($urandom)) >>> $urandom_range(14));
    endcase
  endfunction

  // Receiver: random stalls, with one long hold-off while the sender keeps going
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    repeat (300) begin
      @(negedge clk_i);
      out_ch.ready = $urandom_range(3) != 0;
    end
    out_ch.ready = 1'b0;
    repeat (150) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(9) < 3) begin
        out_ch.ready = 1'b1;
      end else begin
        hold = gap_length();
        out_ch.ready = hold == 0;
        repeat (hold) @(negedge clk_i);
        out_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (stimulus_done && pending == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no progress for %0d cycles", $time, IdleLimit);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] dir_a[$], dir_b[$];
    logic [15:0] a, b;
    int waited;
    dir_a = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0001, 16'h0003,
              16'h0004, 16'hfffd, 16'h7fff, 16'hffff, 16'h0001, 16'h0005, 16'h0064,
              16'hfffb, 16'h8000};
    dir_b = '{16'h0000, 16'h0005, 16'hfffb, 16'h8000, 16'h7fff, 16'h0000, 16'h0000,
              16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0004,
              16'h0003, 16'h0004, 16'h8000, 16'h0001, 16'h0001, 16'hfffb, 16'h0001,
              16'hfffb, 16'h0001};
    stimulus_done = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners: zeros, extremes, equal magnitudes, both orderings
    foreach (dir_a[i]) send_beat(dir_a[i], dir_b[i]);

    for (int i = 0; i < RandomBeats; i++) begin
      a = random_operand();
      b = random_operand();
      if ($urandom_range(15) == 0) a = 16'h0000;
      if ($urandom_range(31) == 0) b = 16'h0000;
      if ($urandom_range(15) == 0) b = $urandom_range(1) ? a : -a;
      send_beat(a, b);
    end
    in_ch.valid = 1'b0;
    stimulus_done = 1'b1;

    // Drain, then allow for the pipeline depth
    while (pending != 0) @(negedge clk_i);
    waited = 0;
    while (waited < 2 * Latency) begin
      @(negedge clk_i);
      waited++;
    end

    $display("Checked %0d rotations (%0d with a saturated code) under random stalls.",
             checked, saturated);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
